// ===== rtl/core/rhcc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV color classifier package
// Shared widths, codes, job record and the restoring divide step.
// ----------------------------------------------------------------------------
package rhcc_pkg;

  localparam int RAW_BITS    = 10;
  // Every quotient (hue, saturation, value) stays below 2**QUO_W.
  localparam int QUO_W       = 9;
  localparam int NUM_W       = RAW_BITS + QUO_W;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int CNT_W       = 17;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(4000);
  localparam logic [RAW_BITS-1:0] FULL_SCALE  = '1;

  typedef logic [RAW_BITS-1:0] raw_t;
  typedef logic [NUM_W-1:0]    num_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = CFG_IDX_W'(0),
    REG_LIMIT = CFG_IDX_W'(1)
  } rhcc_reg_e;

  typedef enum logic {
    MODE_HUE_FIRST  = 1'b0,
    MODE_LUMA_FIRST = 1'b1
  } rhcc_mode_e;

  typedef enum logic [3:0] {
    CLS_WHITE  = 4'd0,
    CLS_BLACK  = 4'd1,
    CLS_RED    = 4'd2,
    CLS_GREEN  = 4'd3,
    CLS_BLUE   = 4'd4,
    CLS_YELLOW = 4'd5,
    CLS_WOOD   = 4'd6,
    CLS_GRAY   = 4'd7,
    CLS_ERROR  = 4'd8
  } rhcc_class_e;

  // Request handed from the front end to the divider back end.
  typedef struct packed {
    raw_t red;
    raw_t green;
    raw_t blue;
    raw_t max_val;
    raw_t delta;
    num_t hue_num;
    num_t sat_num;
    num_t val_num;
    logic err;
  } rhcc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rhcc_q_stat_t;

  // Partial remainder on top, dividend bits shifting out / quotient bits in below.
  typedef struct packed {
    raw_t             rem;
    logic [QUO_W-1:0] nq;
  } rhcc_lane_t;

  function automatic rhcc_lane_t div_step(rhcc_lane_t lane, raw_t divisor);
    logic [RAW_BITS:0] trial;
    rhcc_lane_t        nxt;
    trial  = {lane.rem, lane.nq[QUO_W-1]};
    nxt.nq = {lane.nq[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      nxt.rem   = RAW_BITS'(trial - {1'b0, divisor});
      nxt.nq[0] = 1'b1;
    end else begin
      nxt.rem = trial[RAW_BITS-1:0];
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/rhcc_if.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV color classifier channels
// Sample, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rhcc_in_if import rhcc_pkg::*; ();
  logic valid;
  logic ready;
  raw_t red_raw;
  raw_t green_raw;
  raw_t blue_raw;

  modport source (output valid, output red_raw, output green_raw, output blue_raw,
                  input ready);
  modport sink   (input valid, input red_raw, input green_raw, input blue_raw,
                  output ready);
endinterface

interface rhcc_out_if import rhcc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] color_class;
  logic [8:0] hue_deg;
  logic [6:0] sat_pct;
  logic [6:0] val_pct;

  modport source (output valid, output color_class, output hue_deg, output sat_pct,
                  output val_pct, input ready);
  modport sink   (input valid, input color_class, input hue_deg, input sat_pct,
                  input val_pct, output ready);
endinterface

interface rhcc_cfg_if import rhcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rhcc_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Accepts samples, finds max/min, builds divider numerators, counts samples.
// ----------------------------------------------------------------------------
module rhcc_front import rhcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  rhcc_in_if.sink            in_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  rhcc_q_stat_t       q_stat_i,
  output logic               push_o,
  output rhcc_job_t          job_o
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  sector_e          sector;
  raw_t             max_val, min_val, delta, hi, lo, mag;
  logic             pos;
  logic [8:0]       coef;
  num_t             base, sixty, hue_num;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    priority if (in_i.red_raw >= in_i.green_raw && in_i.red_raw >= in_i.blue_raw) begin
      sector  = SEC_RED;
      max_val = in_i.red_raw;
      min_val = (in_i.green_raw < in_i.blue_raw) ? in_i.green_raw : in_i.blue_raw;
      hi      = in_i.green_raw;
      lo      = in_i.blue_raw;
    end else if (in_i.green_raw >= in_i.blue_raw) begin
      sector  = SEC_GREEN;
      max_val = in_i.green_raw;
      min_val = (in_i.red_raw < in_i.blue_raw) ? in_i.red_raw : in_i.blue_raw;
      hi      = in_i.blue_raw;
      lo      = in_i.red_raw;
    end else begin
      sector  = SEC_BLUE;
      max_val = in_i.blue_raw;
      min_val = (in_i.red_raw < in_i.green_raw) ? in_i.red_raw : in_i.green_raw;
      hi      = in_i.red_raw;
      lo      = in_i.green_raw;
    end
    delta = max_val - min_val;
    pos   = (hi >= lo);
    mag   = pos ? (hi - lo) : (lo - hi);

    // Red sector with a negative offset wraps around by a full turn.
    unique case (sector)
      SEC_RED:   coef = pos ? 9'd0 : 9'd360;
      SEC_GREEN: coef = 9'd120;
      SEC_BLUE:  coef = 9'd240;
      default:   coef = 9'd0;
    endcase

    base    = NUM_W'(delta) * NUM_W'(coef);
    sixty   = NUM_W'(mag) * NUM_W'(60);
    hue_num = pos ? (base + sixty) : (base - sixty);
  end

  // Saturate at all ones.
  assign cnt_d = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push_o) begin
      cnt_q <= cnt_d;
    end
  end

  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && in_i.ready;

  assign job_o.red     = in_i.red_raw;
  assign job_o.green   = in_i.green_raw;
  assign job_o.blue    = in_i.blue_raw;
  assign job_o.max_val = max_val;
  assign job_o.delta   = delta;
  assign job_o.hue_num = hue_num;
  assign job_o.sat_num = NUM_W'(delta) * NUM_W'(100);
  assign job_o.val_num = NUM_W'(max_val) * NUM_W'(100);
  assign job_o.err     = (cnt_d > CNT_W'(limit_i));

endmodule

// ===== rtl/core/rhcc_queue.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV request queue
// Small FIFO that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module rhcc_queue import rhcc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rhcc_job_t    job_i,
  input  logic         pop_i,
  output rhcc_job_t    job_o,
  output rhcc_q_stat_t stat_o
);

  rhcc_job_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] ptr);
    return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign job_o        = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== rtl/core/rhcc_back.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV back end
// Two bit-serial divider lanes for hue and saturation, a shift-and-correct
// divide by full scale for value, then the color rule sets and the output
// register.
// ----------------------------------------------------------------------------
module rhcc_back import rhcc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rhcc_job_t    job_i,
  input  rhcc_q_stat_t q_stat_i,
  output logic         pop_o,
  input  rhcc_mode_e   mode_i,
  rhcc_out_if.source   out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [STEP_W-1:0]         step_q;
  rhcc_lane_t                hue_lane_q, sat_lane_q;
  rhcc_lane_t                hue_step, sat_step;
  num_t                      val_num_q;
  logic [NUM_W-RAW_BITS-1:0] val_hi;
  logic [RAW_BITS:0]         val_rem;
  raw_t                      hue_div_q, sat_div_q;
  raw_t                      red_q, green_q, blue_q;
  logic                      err_q, hue_zero_q, sat_zero_q;
  logic                      out_valid_q;
  rhcc_class_e               out_class_q;
  logic [8:0]                out_hue_q;
  logic [6:0]                out_sat_q, out_val_q;
  logic [8:0]                hue;
  logic [6:0]                sat, val;
  rhcc_class_e               cls;
  logic                      out_free;

  function automatic rhcc_class_e classify(rhcc_mode_e mode, logic [8:0] h, logic [6:0] s,
                                           logic [6:0] v, raw_t r, raw_t g, raw_t b);
    logic [RAW_BITS:0] rg, rb;
    rhcc_class_e       c;
    rg = {1'b0, r} + {1'b0, g};
    rb = {1'b0, r} + {1'b0, b};
    if (mode == MODE_HUE_FIRST) begin
      priority if ((h > 9'd350 || h < 9'd10) && s > 7'd70) c = CLS_RED;
      else if (h > 9'd330 || h < 9'd70) c = (s > 7'd75) ? CLS_YELLOW : CLS_WOOD;
      else if (rg < {1'b0, b})          c = CLS_BLUE;
      else if (rb < {1'b0, g})          c = CLS_GREEN;
      else if (v < 7'd10)               c = CLS_BLACK;
      else if (v > 7'd20)               c = CLS_WHITE;
      else                              c = CLS_GRAY;
    end else begin
      priority if (v < 7'd10)              c = CLS_BLACK;
      else if (s < 7'd35)                  c = CLS_WHITE;
      else if (s < 7'd45 && v < 7'd40)     c = CLS_GRAY;
      else if (h > 9'd330 || h < 9'd30)    c = CLS_RED;
      else if (h < 9'd80)                  c = (s > 7'd65) ? CLS_YELLOW : CLS_WOOD;
      else if (h < 9'd170)                 c = CLS_GREEN;
      else                                 c = CLS_BLUE;
    end
    return c;
  endfunction

  assign hue_step = div_step(hue_lane_q, hue_div_q);
  assign sat_step = div_step(sat_lane_q, sat_div_q);

  // Divide by full scale: x = 1024*hi + lo = FS*hi + (hi + lo), one correction.
  assign val_hi  = val_num_q[NUM_W-1:RAW_BITS];
  assign val_rem = {1'b0, val_num_q[RAW_BITS-1:0]} + (RAW_BITS+1)'(val_hi);

  // Gray sample gives hue 0, black sample gives saturation 0.
  assign hue = hue_zero_q ? '0 : hue_lane_q.nq;
  assign sat = sat_zero_q ? '0 : sat_lane_q.nq[6:0];
  assign val = 7'(val_hi) + 7'(val_rem >= {1'b0, FULL_SCALE});
  assign cls = err_q ? CLS_ERROR : classify(mode_i, hue, sat, val, red_q, green_q, blue_q);

  assign pop_o    = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      hue_lane_q  <= '0;
      sat_lane_q  <= '0;
      val_num_q   <= '0;
      hue_div_q   <= '0;
      sat_div_q   <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      err_q       <= 1'b0;
      hue_zero_q  <= 1'b0;
      sat_zero_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_class_q <= CLS_WHITE;
      out_hue_q   <= '0;
      out_sat_q   <= '0;
      out_val_q   <= '0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            hue_lane_q <= rhcc_lane_t'(job_i.hue_num);
            sat_lane_q <= rhcc_lane_t'(job_i.sat_num);
            val_num_q  <= job_i.val_num;
            hue_div_q  <= job_i.delta;
            sat_div_q  <= job_i.max_val;
            red_q      <= job_i.red;
            green_q    <= job_i.green;
            blue_q     <= job_i.blue;
            err_q      <= job_i.err;
            hue_zero_q <= (job_i.delta == '0);
            sat_zero_q <= (job_i.max_val == '0);
            step_q     <= '0;
            state_q    <= ST_DIV;
          end
        end
        ST_DIV: begin
          hue_lane_q <= hue_step;
          sat_lane_q <= sat_step;
          if (step_q == STEP_W'(QUO_W - 1)) begin
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DONE: begin
          // Hold the finished result until the output register frees up.
          if (out_free) begin
            out_class_q <= cls;
            out_hue_q   <= hue;
            out_sat_q   <= sat;
            out_val_q   <= val;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.color_class = out_class_q;
  assign out_o.hue_deg     = out_hue_q;
  assign out_o.sat_pct     = out_sat_q;
  assign out_o.val_pct     = out_val_q;

endmodule

// ===== rtl/core/rgb_hsv_color_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV color classifier
// An accepted sample passes through the queue, a load state, the divider lanes
// and the output register. The back end takes one sample at a time: load, the
// nine-step divider lanes, then unload, before it can take the next sample.
// A two-entry queue lets the input side accept while the back end is busy.
// Reset: mode 0, sample limit 4000, sample counter cleared, queue empty.
// ----------------------------------------------------------------------------
module rgb_hsv_color_classifier_unit import rhcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rhcc_cfg_if.sink   cfg_i,
  rhcc_in_if.sink    in_i,
  rhcc_out_if.source out_o
);

  rhcc_mode_e         mode_q;
  logic [LIMIT_W-1:0] limit_q;
  rhcc_job_t          push_job, head_job;
  rhcc_q_stat_t       q_stat;
  logic               push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HUE_FIRST;
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (rhcc_reg_e'(cfg_i.index))
        REG_MODE:  mode_q  <= rhcc_mode_e'(cfg_i.data[0]);
        REG_LIMIT: limit_q <= cfg_i.data[LIMIT_W-1:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  rhcc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .limit_i  (limit_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  rhcc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  rhcc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (head_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .mode_i   (mode_q),
    .out_o    (out_o)
  );

endmodule

// ===== rtl/core/rhcc_checker.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV classifier port checker
// Watches the top-level channels for held results, field ranges and
// results without a matching sample.
// ----------------------------------------------------------------------------
module rhcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] color_class_i,
  input logic [8:0] hue_deg_i,
  input logic [6:0] sat_pct_i,
  input logic [6:0] val_pct_i
);

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(color_class_i) &&
      $stable(hue_deg_i) && $stable(sat_pct_i) && $stable(val_pct_i))
    else $error("result changed while stalled");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> hue_deg_i < 9'd360 && sat_pct_i <= 7'd100 && val_pct_i <= 7'd100)
    else $error("hue, saturation or value out of range");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 3'd0)
    else $error("result delivered without an accepted sample");

endmodule

bind rgb_hsv_color_classifier_unit rhcc_checker u_rhcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .color_class_i (out_o.color_class),
  .hue_deg_i     (out_o.hue_deg),
  .sat_pct_i     (out_o.sat_pct),
  .val_pct_i     (out_o.val_pct)
);

// ===== bench/rgb_hsv_color_classifier_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSV color classifier unit test
// Feeds raw RGB samples through the sample channel, predicts hue, saturation,
// value and color class for both rule sets and the sample limit, and checks
// every result in order while both sides idle in random bursts, but for the last phase.
// ----------------------------------------------------------------------------
module rgb_hsv_color_classifier_unit_test;
  import rhcc_pkg::*;

  localparam int          QUIET_LIMIT = 2000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int unsigned COUNTER_MAX = (1 << CNT_W) - 1;

  typedef struct packed {
    raw_t red;
    raw_t green;
    raw_t blue;
  } rgb_sample_t;

  typedef struct {
    rhcc_class_e color;
    logic [8:0]  hue;
    logic [6:0]  sat;
    logic [6:0]  val;
  } hsv_class_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rhcc_in_if  sample_if ();
  rhcc_out_if result_if ();
  rhcc_cfg_if reg_if ();

  rgb_hsv_color_classifier_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (reg_if),
    .in_i   (sample_if),
    .out_o  (result_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rgb_sample_t   sample_queue[$];
  hsv_class_t    pending_results[$];
  hsv_class_t    want;
  rhcc_mode_e    active_mode;
  logic [15:0]   active_limit;
  int unsigned   samples_seen;
  int            mismatches;
  int            gap_left;
  int            stall_left;
  int            quiet_cycles;
  logic          send_gaps;
  logic          recv_stalls;

  // Corners: zero, full gray, primaries, sector ties, wrapped hue, mid tones.
  rgb_sample_t corner_samples [12] = '{
    {10'd0,    10'd0,    10'd0},
    {10'd1023, 10'd1023, 10'd1023},
    {10'd1023, 10'd0,    10'd0},
    {10'd0,    10'd1023, 10'd0},
    {10'd0,    10'd0,    10'd1023},
    {10'd1023, 10'd1023, 10'd0},
    {10'd0,    10'd1023, 10'd1023},
    {10'd1023, 10'd0,    10'd1023},
    {10'd1023, 10'd0,    10'd1},
    {10'd150,  10'd150,  10'd150},
    {10'd600,  10'd300,  10'd100},
    {10'd50,   10'd50,   10'd60}
  };

  function automatic hsv_class_t predict_hsv(raw_t red, raw_t green, raw_t blue,
                                             rhcc_mode_e mode, logic over_limit);
    int         r, g, b, mx, mn, d, num, h, s, v;
    hsv_class_t res;
    r = red;
    g = green;
    b = blue;
    h = 0;
    s = 0;
    if (r >= g && r >= b) begin
      mx = r;
      mn = (g < b) ? g : b;
    end else if (g >= r && g >= b) begin
      mx = g;
      mn = (r < b) ? r : b;
    end else begin
      mx = b;
      mn = (r < g) ? r : g;
    end
    d = mx - mn;
    if (d > 0) begin
      // Red sector wraps below zero; lift it by a full turn.
      if (mx == r) begin
        num = 60 * (g - b);
        if (num < 0) num = num + 360 * d;
      end else if (mx == g) begin
        num = 60 * (b - r) + 120 * d;
      end else begin
        num = 60 * (r - g) + 240 * d;
      end
      h = num / d;
      if (h >= 360) h = h - 360;
    end
    if (mx > 0) s = (100 * d) / mx;
    v = (100 * mx) / int'(FULL_SCALE);

    if (mode == MODE_HUE_FIRST) begin
      if ((h > 350 || h < 10) && s > 70) res.color = CLS_RED;
      else if (h > 330 || h < 70) res.color = (s > 75) ? CLS_YELLOW : CLS_WOOD;
      else if (r + g < b) res.color = CLS_BLUE;
      else if (r + b < g) res.color = CLS_GREEN;
      else if (v < 10) res.color = CLS_BLACK;
      else if (v > 20) res.color = CLS_WHITE;
      else res.color = CLS_GRAY;
    end else begin
      if (v < 10) res.color = CLS_BLACK;
      else if (s < 35) res.color = CLS_WHITE;
      else if (s < 45 && v < 40) res.color = CLS_GRAY;
      else if (h > 330 || h < 30) res.color = CLS_RED;
      else if (h < 80) res.color = (s > 65) ? CLS_YELLOW : CLS_WOOD;
      else if (h < 170) res.color = CLS_GREEN;
      else res.color = CLS_BLUE;
    end
    if (over_limit) res.color = CLS_ERROR;
    res.hue = 9'(h);
    res.sat = 7'(s);
    res.val = 7'(v);
    return res;
  endfunction

  function automatic raw_t jitter(int base, int spread);
    int x;
    x = base - spread + int'($urandom_range(0, 2 * spread));
    if (x < 0) x = 0;
    if (x > 1023) x = 1023;
    return raw_t'(x);
  endfunction

  function automatic rgb_sample_t random_sample();
    rgb_sample_t smp;
    int          hi;
    case ($urandom_range(0, 5))
      0, 1: smp = rgb_sample_t'($urandom);
      2: begin
        // near gray
        hi = $urandom_range(0, 1023);
        smp = {jitter(hi, 12), jitter(hi, 12), jitter(hi, 12)};
      end
      3: smp = {raw_t'($urandom_range(0, 110)), raw_t'($urandom_range(0, 110)),
                raw_t'($urandom_range(0, 110))};
      4: begin
        hi = $urandom_range(300, 1023);
        smp = {raw_t'(hi), raw_t'($urandom_range(0, hi)), raw_t'($urandom_range(0, hi))};
      end
      default: begin
        // two strong channels: yellow, cyan or magenta shades
        hi = $urandom_range(300, 1023);
        smp = {jitter(hi, hi / 4), jitter(hi, hi / 4), raw_t'($urandom_range(0, hi / 3))};
      end
    endcase
    case ($urandom_range(0, 2))
      1: smp = {smp.green, smp.blue, smp.red};
      2: smp = {smp.blue, smp.red, smp.green};
      default: ;
    endcase
    return smp;
  endfunction

  task automatic write_reg(rhcc_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= value;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
    case (idx)
      REG_MODE:  active_mode = rhcc_mode_e'(value[0]);
      REG_LIMIT: active_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_random(int count);
    repeat (count) sample_queue.push_back(random_sample());
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Sample driver: accept, predict, then present the next request or a gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        if (samples_seen < COUNTER_MAX) samples_seen++;
        pending_results.push_back(predict_hsv(sample_if.red_raw, sample_if.green_raw,
                                              sample_if.blue_raw, active_mode,
                                              samples_seen > active_limit));
        void'(sample_queue.pop_front());
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (send_gaps && gap_left > 0) begin
          gap_left <= gap_left - 1;
          sample_if.valid <= 1'b0;
        end else if (send_gaps && $urandom_range(0, 11) == 0) begin
          gap_left <= $urandom_range(0, 14);
          sample_if.valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          sample_if.valid     <= 1'b1;
          sample_if.red_raw   <= sample_queue[0].red;
          sample_if.green_raw <= sample_queue[0].green;
          sample_if.blue_raw  <= sample_queue[0].blue;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b1;
      stall_left <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: class=%0d hue=%0d sat=%0d val=%0d",
                     result_if.color_class, result_if.hue_deg, result_if.sat_pct,
                     result_if.val_pct);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result_if.color_class !== want.color || result_if.hue_deg !== want.hue ||
              result_if.sat_pct !== want.sat || result_if.val_pct !== want.val) begin
            if (mismatches < 10)
              $display("mismatch: exp cls=%0d h=%0d s=%0d v=%0d got cls=%0d h=%0d s=%0d v=%0d",
                       want.color, want.hue, want.sat, want.val, result_if.color_class,
                       result_if.hue_deg, result_if.sat_pct, result_if.val_pct);
            mismatches++;
          end
        end
      end
      if (recv_stalls && stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_if.ready <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 14);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no channel moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready) || (reg_if.valid && reg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_if.valid     = 1'b0;
    sample_if.red_raw   = '0;
    sample_if.green_raw = '0;
    sample_if.blue_raw  = '0;
    result_if.ready     = 1'b0;
    reg_if.valid        = 1'b0;
    reg_if.index        = REG_MODE;
    reg_if.data         = '0;
    active_mode  = MODE_HUE_FIRST;
    active_limit = LIMIT_RESET;
    samples_seen = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    send_gaps    = 1'b1;
    recv_stalls  = 1'b1;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hue-first rules, limit out of reach.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_HUE_FIRST));
    write_reg(REG_LIMIT, 16'hFFFF);
    foreach (corner_samples[i]) sample_queue.push_back(corner_samples[i]);
    queue_random(280);
    wait_drained();

    // Luma-first rules.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LUMA_FIRST));
    foreach (corner_samples[i]) sample_queue.push_back(corner_samples[i]);
    queue_random(280);
    wait_drained();

    // Cross the sample limit partway through.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_HUE_FIRST));
    write_reg(REG_LIMIT, CFG_DATA_W'(samples_seen + 40));
    queue_random(100);
    wait_drained();

    // Zero limit: every result is forced to error.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LUMA_FIRST));
    write_reg(REG_LIMIT, '0);
    queue_random(60);
    wait_drained();

    write_reg(REG_MODE, CFG_DATA_W'(MODE_HUE_FIRST));
    write_reg(REG_LIMIT, CFG_DATA_W'(LIMIT_RESET));
    queue_random(200);
    wait_drained();

    // Full rate on both sides to finish.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LUMA_FIRST));
    write_reg(REG_LIMIT, 16'hFFFF);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    queue_random(200);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
